>>> hw/rtl/mpa_fpdu_marker_framer_assert.svh
// assertion macros for the mpa fpdu marker framer
// included by the top level, no other dependencies
`ifndef MPA_FPDU_MARKER_FRAMER_ASSERT_SVH
`define MPA_FPDU_MARKER_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define MPAFM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mpafm assertion failed");
`define MPAFM_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mpafm assertion failed");
`else
`define MPAFM_ASSERT(lbl, clk, rst_n, prop)
`define MPAFM_ASSERT_NR(lbl, clk, prop)
`endif

`endif

>>> hw/rtl/mpafm_pkg.sv
// shared types, codes and the crc32c byte update for the mpa fpdu marker framer
// no dependencies
package mpafm_pkg;

    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    // config register indexes
    localparam logic CFG_MARKER_EN = 1'b0;
    localparam logic CFG_CRC_EN    = 1'b1;

    typedef enum logic [2:0] {
        K_DATA = 3'd0,
        K_LEN  = 3'd1,
        K_MARK = 3'd2,
        K_PAD  = 3'd3,
        K_CRC  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      byte_kind;
        logic       run_last;
        logic       frame_end;
    } t_res;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC32C_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/mpa_fpdu_marker_framer.sv
// mpa fpdu transmit framer: one ulpdu byte per input word, framed stream bytes out
// framed bytes leave at one per cycle unless the receiver stalls. a word yields its
// own byte, four marker bytes for each marker due before a byte, and on the last
// byte of a ulpdu up to three pad bytes plus, with crc on, four crc bytes (and any
// markers among them). the single byte emitter in mpafm_engine sets this; the input
// register holds the word while the emitter drains its run, so input stalls only
// during those runs. markers come every MARKER_SPACING stream bytes; depends on mpafm_pkg
`include "mpa_fpdu_marker_framer_assert.svh"

module mpa_fpdu_marker_framer
    import mpafm_pkg::*;
#(
    parameter int MARKER_SPACING = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_ulpdu_length,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_byte_kind,
    output logic        o_run_last,
    output logic        o_frame_end
);

    logic        r_marker_en, r_crc_en;
    logic        r_in_v, r_out_v;
    logic [7:0]  r_data;
    logic [15:0] r_len;
    logic        r_last;
    t_res        r_out, eng_res;
    logic        out_free, adv, done, in_acc;

    assign out_free   = !r_out_v || !i_out_stall;
    assign adv        = r_in_v && out_free;
    assign done       = adv && eng_res.run_last;
    assign o_in_stall = r_in_v && !done;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_en <= 1'b0;
            r_crc_en    <= 1'b0;
            r_in_v      <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MARKER_EN: r_marker_en <= i_cfg_data;
                    CFG_CRC_EN:    r_crc_en    <= i_cfg_data;
                    default:       r_crc_en    <= r_crc_en;
                endcase
            end
            if (in_acc) begin
                r_in_v <= 1'b1;
            end else if (done) begin
                r_in_v <= 1'b0;
            end
            if (adv) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_data <= i_data_byte;
            r_len  <= i_ulpdu_length;
            r_last <= i_last_byte;
        end
        if (adv) begin
            r_out <= eng_res;
        end
    end

    mpafm_engine #(
        .MARKER_SPACING(MARKER_SPACING)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_marker_en (r_marker_en),
        .i_crc_en    (r_crc_en),
        .i_adv       (adv),
        .i_data      (r_data),
        .i_len       (r_len),
        .i_last      (r_last),
        .o_res       (eng_res)
    );

    assign o_out_valid = r_out_v;
    assign o_out_byte  = r_out.out_byte;
    assign o_byte_kind = r_out.byte_kind;
    assign o_run_last  = r_out.run_last;
    assign o_frame_end = r_out.frame_end;

    // a marker never closes a run, the frame end always does
    `MPAFM_ASSERT(a_mark_not_last, i_clk, i_rst_n, o_out_valid && (o_byte_kind == K_MARK) |-> !o_run_last)
    `MPAFM_ASSERT(a_end_is_last, i_clk, i_rst_n, o_out_valid && o_frame_end |-> o_run_last)
    `MPAFM_ASSERT(a_crc_last_ends, i_clk, i_rst_n, o_out_valid && (o_byte_kind == K_CRC) && o_run_last |-> o_frame_end)
    `MPAFM_ASSERT_NR(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

>>> hw/rtl/mpafm_engine.sv
// framing engine: picks the next stream byte and keeps stream, frame and crc state
// depends on mpafm_pkg
module mpafm_engine
    import mpafm_pkg::*;
#(
    parameter int MARKER_SPACING = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_marker_en,
    input  logic        i_crc_en,
    input  logic        i_adv,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_len,
    input  logic        i_last,
    output t_res        o_res
);

    localparam int PW = $clog2(MARKER_SPACING);
    localparam logic [PW-1:0] PH_LAST = PW'(MARKER_SPACING - 1);

    typedef enum logic [2:0] {
        S_DATA = 3'b001,
        S_PAD  = 3'b010,
        S_CRC  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [PW-1:0] r_phase;
    logic [16:0]   r_foff;
    logic [15:0]   r_idx, n_idx;
    logic [31:0]   r_crc;
    logic          r_mk_act;
    logic [1:0]    r_mk_cnt;
    logic [15:0]   r_mk_off;
    logic [31:0]   r_crc_val, n_crc_val;
    logic [1:0]    r_crc_cnt, n_crc_cnt;

    logic          mk_start, in_mark, pad_more;
    logic [1:0]    mk_idx;
    logic [15:0]   mk_off, hdr;
    logic [16:0]   foff_inc;
    logic [31:0]   crc_inv;
    t_res          res;

    assign mk_start = i_marker_en && (r_phase == '0) && !r_mk_act;
    assign in_mark  = r_mk_act || mk_start;
    assign mk_idx   = r_mk_act ? r_mk_cnt : 2'd0;
    assign mk_off   = r_mk_act ? r_mk_off : r_foff[15:0];
    assign hdr      = i_len - 16'd2;
    assign foff_inc = r_foff + 17'd1;
    assign pad_more = (foff_inc[1:0] != 2'b00);
    assign crc_inv  = ~r_crc;

    always_comb begin
        res       = '{out_byte: 8'd0, byte_kind: K_DATA, run_last: 1'b0, frame_end: 1'b0};
        n_state   = r_state;
        n_idx     = r_idx;
        n_crc_val = r_crc_val;
        n_crc_cnt = r_crc_cnt;
        if (in_mark) begin
            res.byte_kind = K_MARK;
            case (mk_idx)
                2'd2:    res.out_byte = mk_off[15:8];
                2'd3:    res.out_byte = mk_off[7:0];
                default: res.out_byte = 8'd0;
            endcase
        end else begin
            case (r_state)
                S_DATA: begin
                    if (r_idx == 16'd0) begin
                        res.out_byte  = hdr[15:8];
                        res.byte_kind = K_LEN;
                    end else if (r_idx == 16'd1) begin
                        res.out_byte  = hdr[7:0];
                        res.byte_kind = K_LEN;
                    end else begin
                        res.out_byte  = i_data;
                        res.byte_kind = K_DATA;
                    end
                    n_idx = (r_idx == 16'hFFFF) ? r_idx : r_idx + 16'd1;
                    if (!i_last) begin
                        res.run_last = 1'b1;
                    end else if (pad_more) begin
                        n_state = S_PAD;
                    end else if (i_crc_en) begin
                        n_state   = S_CRC;
                        n_crc_cnt = 2'd0;
                    end else begin
                        res.run_last  = 1'b1;
                        res.frame_end = 1'b1;
                    end
                end
                S_PAD: begin
                    res.out_byte  = 8'd0;
                    res.byte_kind = K_PAD;
                    if (!pad_more) begin
                        if (i_crc_en) begin
                            n_state   = S_CRC;
                            n_crc_cnt = 2'd0;
                        end else begin
                            res.run_last  = 1'b1;
                            res.frame_end = 1'b1;
                        end
                    end
                end
                S_CRC: begin
                    res.byte_kind = K_CRC;
                    case (r_crc_cnt)
                        2'd0: begin
                            res.out_byte = crc_inv[31:24];
                            n_crc_val    = crc_inv;
                        end
                        2'd1:    res.out_byte = r_crc_val[23:16];
                        2'd2:    res.out_byte = r_crc_val[15:8];
                        default: res.out_byte = r_crc_val[7:0];
                    endcase
                    n_crc_cnt = r_crc_cnt + 2'd1;
                    if (r_crc_cnt == 2'd3) begin
                        res.run_last  = 1'b1;
                        res.frame_end = 1'b1;
                    end
                end
                default: n_state = S_DATA;
            endcase
            if (res.frame_end) begin
                n_state = S_DATA;
                n_idx   = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_DATA;
            r_phase   <= '0;
            r_foff    <= '0;
            r_idx     <= '0;
            r_crc     <= CRC_INIT;
            r_mk_act  <= 1'b0;
            r_mk_cnt  <= 2'd0;
            r_crc_cnt <= 2'd0;
        end else if (i_adv) begin
            r_mk_act <= in_mark && (mk_idx != 2'd3);
            r_mk_cnt <= mk_idx + 2'd1;
            r_phase  <= (r_phase == PH_LAST) ? '0 : r_phase + 1'b1;
            if (res.frame_end) begin
                r_foff <= '0;
                r_crc  <= CRC_INIT;
            end else begin
                r_foff <= foff_inc;
                r_crc  <= crc32c_byte(r_crc, res.out_byte);
            end
            if (!in_mark) begin
                r_state   <= n_state;
                r_idx     <= n_idx;
                r_crc_cnt <= n_crc_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && mk_start) begin
            r_mk_off <= r_foff[15:0];
        end
        if (i_adv && !in_mark) begin
            r_crc_val <= n_crc_val;
        end
    end

    assign o_res = res;

endmodule

>>> test/mpafm_checker.sv
// checker for the mpa fpdu marker framer
// watches the config port and both word channels, predicts the framed byte stream
// and compares it; depends on mpafm_pkg
module mpafm_checker
    import mpafm_pkg::*;
#(
    parameter int MARKER_SPACING = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_ulpdu_length,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic [2:0]  i_byte_kind,
    input  logic        i_run_last,
    input  logic        i_frame_end,
    output int          o_fail_count,
    output int          o_pending
);

    logic        marker_on;
    logic        crc_on;
    int          seq_pos;
    logic [16:0] fpdu_offset;
    logic [15:0] ulpdu_count;
    logic [31:0] crc_reg;
    t_res        run_q[$];
    t_res        expected_bytes[$];
    int          mismatches    = 0;
    int          bytes_checked = 0;

    function automatic logic [31:0] crc32c_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC32C_POLY;
            end
        end
        return r;
    endfunction

    task automatic emit_raw(input logic [7:0] b, input t_kind k);
        run_q.push_back('{out_byte: b, byte_kind: k, run_last: 1'b0, frame_end: 1'b0});
        crc_reg     = crc32c_next(crc_reg, b);
        seq_pos     = (seq_pos + 1) % MARKER_SPACING;
        fpdu_offset = fpdu_offset + 17'd1;
    endtask

    task automatic marker_if_due();
        logic [15:0] off;
        off = fpdu_offset[15:0];
        if (marker_on && seq_pos == 0) begin
            emit_raw(8'h00, K_MARK);
            emit_raw(8'h00, K_MARK);
            emit_raw(off[15:8], K_MARK);
            emit_raw(off[7:0], K_MARK);
        end
    endtask

    task automatic emit(input logic [7:0] b, input t_kind k);
        marker_if_due();
        emit_raw(b, k);
    endtask

    task automatic predict_framing(input logic [7:0] d, input logic [15:0] len, input logic last);
        logic [15:0] hdr;
        logic [31:0] crc_out;
        t_res        r;
        hdr = len - 16'd2;
        run_q.delete();
        if (ulpdu_count == 16'd0) begin
            fpdu_offset = '0;
            crc_reg     = CRC_INIT;
            emit(hdr[15:8], K_LEN);
        end else if (ulpdu_count == 16'd1) begin
            emit(hdr[7:0], K_LEN);
        end else begin
            emit(d, K_DATA);
        end
        if (ulpdu_count != 16'hFFFF) begin
            ulpdu_count = ulpdu_count + 16'd1;
        end
        if (last) begin
            while (fpdu_offset[1:0] != 2'd0) begin
                emit(8'h00, K_PAD);
            end
            if (crc_on) begin
                // value fixed once any marker ahead of the first crc byte is out
                marker_if_due();
                crc_out = ~crc_reg;
                for (int k = 0; k < 4; k++) begin
                    if (k != 0) begin
                        marker_if_due();
                    end
                    emit_raw(crc_out[31 - 8 * k -: 8], K_CRC);
                end
            end
            r = run_q[run_q.size() - 1];
            r.frame_end = 1'b1;
            run_q[run_q.size() - 1] = r;
            ulpdu_count = '0;
            fpdu_offset = '0;
            crc_reg     = CRC_INIT;
        end
        r = run_q[run_q.size() - 1];
        r.run_last = 1'b1;
        run_q[run_q.size() - 1] = r;
        foreach (run_q[i]) begin
            expected_bytes.push_back(run_q[i]);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_byte();
        t_res want;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h kind %0d", i_out_byte, i_byte_kind));
        end else begin
            want = expected_bytes.pop_front();
            if (i_out_byte !== want.out_byte || i_byte_kind !== want.byte_kind
                || i_run_last !== want.run_last || i_frame_end !== want.frame_end) begin
                report_mismatch($sformatf(
                    "byte %0d got %02h/%0d/%b/%b want %02h/%0d/%b/%b", bytes_checked,
                    i_out_byte, i_byte_kind, i_run_last, i_frame_end,
                    want.out_byte, want.byte_kind, want.run_last, want.frame_end));
            end
            bytes_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            marker_on   = 1'b0;
            crc_on      = 1'b0;
            seq_pos     = 0;
            fpdu_offset = '0;
            ulpdu_count = '0;
            crc_reg     = CRC_INIT;
            expected_bytes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MARKER_EN: marker_on = i_cfg_data;
                    CFG_CRC_EN:    crc_on = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_framing(i_data_byte, i_ulpdu_length, i_last_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                check_byte();
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_bytes.size();
    end

endmodule

>>> test/tb.sv
// testbench top for the mpa fpdu marker framer: clock, reset, config writes and word
// stimulus with idle and stall mixes; checking lives in mpafm_checker
// depends on mpafm_pkg, mpafm_checker and mpa_fpdu_marker_framer
module tb;
    import mpafm_pkg::*;

    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic        cfg_index    = 1'b0;
    logic        cfg_data     = 1'b0;
    logic        in_valid     = 1'b0;
    logic [7:0]  data_byte    = 8'h00;
    logic [15:0] ulpdu_length = 16'h0000;
    logic        last_byte    = 1'b0;
    logic        out_stall    = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [2:0]  byte_kind;
    logic        run_last;
    logic        frame_end;
    int          fail_count;
    int          pending;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_reqs   = 0;
    int words_sent  = 0;
    int ulpdus_sent = 0;

    always #5 clk = ~clk;

    mpa_fpdu_marker_framer uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .i_ulpdu_length (ulpdu_length),
        .i_last_byte    (last_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_byte_kind    (byte_kind),
        .o_run_last     (run_last),
        .o_frame_end    (frame_end)
    );

    mpafm_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .i_ulpdu_length (ulpdu_length),
        .i_last_byte    (last_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_byte     (out_byte),
        .i_byte_kind    (byte_kind),
        .i_run_last     (run_last),
        .i_frame_end    (frame_end),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // receiver side: random stall, or a long hold-off on request
    initial begin
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input logic [7:0] d, input logic [15:0] len, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= d;
        ulpdu_length <= len;
        last_byte    <= last;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        words_sent++;
        if (last) begin
            ulpdus_sent++;
        end
    endtask

    task automatic send_ulpdu(input int n, input bit noisy, input logic [15:0] len);
        logic [15:0] word_len;
        for (int i = 0; i < n; i++) begin
            word_len = noisy ? 16'($urandom_range(65535)) : len;
            send_word(8'($urandom_range(255)), word_len, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic mk, input logic cc, input int idle, input int stall,
                             input int n_words);
        int start;
        int n;
        wait_drained();
        write_reg(CFG_MARKER_EN, mk);
        write_reg(CFG_CRC_EN, cc);
        idle_pct  = idle;
        stall_pct = stall;
        start     = words_sent;
        while (words_sent - start < n_words) begin
            if ($urandom_range(99) < 80) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
                send_ulpdu(n, 1'b0, 16'(n));
            end else begin
                send_ulpdu($urandom_range(1, 6), 1'b1, 16'h0000);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, markers and crc on: first word gets a marker at frame start
        write_reg(CFG_MARKER_EN, 1'b1);
        write_reg(CFG_CRC_EN, 1'b1);
        send_word(8'hFF, 16'd1, 1'b1);
        send_word(8'h00, 16'd0, 1'b0);
        send_word(8'hFF, 16'd0, 1'b1);
        send_word(8'hFF, 16'hFFFF, 1'b0);
        send_word(8'h00, 16'hFFFF, 1'b0);
        send_word(8'hFF, 16'hFFFF, 1'b1);
        send_word(8'h00, 16'd6, 1'b0);
        send_word(8'hFF, 16'd6, 1'b0);
        send_word(8'h00, 16'd6, 1'b0);
        send_word(8'hFF, 16'd6, 1'b0);
        send_word(8'hAA, 16'd6, 1'b0);
        send_word(8'h55, 16'd6, 1'b1);
        send_word(8'h5A, 16'h5555, 1'b0);
        send_word(8'hA5, 16'hAAAA, 1'b0);
        send_word(8'hC3, 16'h0003, 1'b1);
        wait_drained();
        write_reg(CFG_MARKER_EN, 1'b0);
        write_reg(CFG_CRC_EN, 1'b0);
        send_word(8'h01, 16'd5, 1'b0);
        send_word(8'h80, 16'd5, 1'b0);
        send_word(8'h7F, 16'd5, 1'b0);
        send_word(8'hFE, 16'd5, 1'b0);
        send_word(8'h10, 16'd5, 1'b1);

        run_phase(1'b1, 1'b1, 0, 0, 10);
        run_phase(1'b0, 1'b1, 83, 0, 10);
        run_phase(1'b1, 1'b0, 0, 83, 10);
        run_phase(1'b0, 1'b0, 26, 26, 10);

        // receiver holds off while a full-rate ulpdu backs up into the input
        wait_drained();
        write_reg(CFG_MARKER_EN, 1'b1);
        write_reg(CFG_CRC_EN, 1'b1);
        idle_pct  = 0;
        stall_pct = 0;
        hold_reqs++;
        send_ulpdu(20, 1'b0, 16'd20);
        wait_drained();

        if (pending != 0) begin
            $display("%0d framed bytes never arrived", pending);
        end
        $display("sent %0d words in %0d ulpdus under all marker and crc settings,", words_sent,
                 ulpdus_sent);
        $display("idle and stall mixes and an input fill-up behind a long receiver hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("mpa_fpdu_marker_framer test passed");
        end else begin
            $display("mpa_fpdu_marker_framer test failed");
        end
        $finish;
    end

    initial begin
        #(30_000_000);
        $display("mpa_fpdu_marker_framer test failed");
        $finish;
    end

endmodule
